// ----- src/crpf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the class repeat pair finder.
// No dependencies; imported by every module of the block but crpf_ram.
package crpf_pkg;

    // Fixed field widths of the stream payloads
    localparam int CLS_W       = 12;
    localparam int IN_VID_W    = 32;
    localparam int OUT_VID_W   = 32;
    localparam int S_TDATA_W   = 48;   // 45 payload bits, padded to bytes
    localparam int M_TDATA_W   = 72;   // 66 payload bits, padded to bytes

    // Default sizing of the class table and stored fields
    localparam int CLASS_COUNT_DEF    = 4096;
    localparam int VERTEX_ID_BITS_DEF = 32;
    localparam int POSITION_BITS_DEF  = 32;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_LVL_W = 3;

    typedef struct packed {
        logic                 end_orientation;
        logic [OUT_VID_W-1:0] end_vertex;
        logic                 start_orientation;
        logic [OUT_VID_W-1:0] start_vertex;
    } pair_t;

    // Queue occupancy as seen by the input side
    typedef struct packed {
        logic [FIFO_LVL_W-1:0] level;
        logic                  empty;
    } fifo_status_t;

endpackage

// ----- src/class_repeat_pair_finder.sv -----
`timescale 1ns / 1ps
// Class repeat pair finder: an input beat is taken while the result queue has
// room for it; it passes stages A and B, and its pair, if any, is then offered
// on the master port through the result queue. Throughput is one beat per cycle
// while the queue has room; table read and write use separate RAM ports.
// Reset (aresetn low, synchronous) empties the pipeline and result queue and
// starts a clearing pass over every class table entry, during which s_tready
// stays low. Depends on crpf_pkg, crpf_ram and crpf_out_fifo.
module class_repeat_pair_finder #(
    parameter int CLASS_COUNT    = crpf_pkg::CLASS_COUNT_DEF,
    parameter int VERTEX_ID_BITS = crpf_pkg::VERTEX_ID_BITS_DEF,
    parameter int POSITION_BITS  = crpf_pkg::POSITION_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [0] orientation, [32:1] vertex_id, [44:33] class_id, rest zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [crpf_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: [31:0] start_vertex, [32] start_orientation,
    //          [64:33] end_vertex, [65] end_orientation, rest zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [crpf_pkg::M_TDATA_W-1:0] m_tdata
);
    import crpf_pkg::*;

    localparam int IDX_W = $clog2(CLASS_COUNT);
    // Table entry layout, lowest bit up: orientation, vertex, position, seen
    localparam int ENT_W = POSITION_BITS + VERTEX_ID_BITS + 2;
    localparam int VID_LO = 1;
    localparam int POS_LO = VERTEX_ID_BITS + 1;
    localparam int SEEN_B = ENT_W - 1;

    // ------------------------------------------------------------------
    // Table clearing pass after reset
    // ------------------------------------------------------------------
    logic             clr_reg, clr_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;

    always_comb begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == IDX_W'(CLASS_COUNT - 1)) begin
                clr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // ------------------------------------------------------------------
    // Input acceptance
    // ------------------------------------------------------------------
    logic         a_valid_reg, b_valid_reg;
    fifo_status_t fifo_st;
    logic [FIFO_LVL_W:0] reserved;
    logic         s_accept;

    // Every beat in flight reserves a queue slot, so the A/B stages never stall.
    assign reserved = {1'b0, fifo_st.level} + (FIFO_LVL_W+1)'(a_valid_reg)
                    + (FIFO_LVL_W+1)'(b_valid_reg);
    assign s_tready = !clr_reg && (reserved < (FIFO_LVL_W+1)'(FIFO_DEPTH));
    assign s_accept = s_tvalid && s_tready;

    logic                 in_ori;
    logic [IN_VID_W-1:0]  in_vid;
    logic [CLS_W-1:0]     in_cls;

    assign in_ori = s_tdata[0];
    assign in_vid = s_tdata[IN_VID_W:1];
    assign in_cls = s_tdata[IN_VID_W+CLS_W:IN_VID_W+1];

    // Position counter, saturating at all ones
    logic [POSITION_BITS-1:0] pos_cnt_reg, pos_cnt_next;

    always_comb begin
        pos_cnt_next = pos_cnt_reg;
        if (s_accept && (pos_cnt_reg != '1)) begin
            pos_cnt_next = pos_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_cnt_reg <= '0;
        end else begin
            pos_cnt_reg <= pos_cnt_next;
        end
    end

    // Class reduction modulo CLASS_COUNT: restoring compare/subtract,
    // upper six steps before stage A, lower six after it.
    logic [CLS_W-1:0] cls_hi_red;

    always_comb begin
        cls_hi_red = in_cls;
        for (int k = CLS_W - 1; k >= CLS_W / 2; k--) begin
            if (64'(cls_hi_red) >= (64'(CLASS_COUNT) << k)) begin
                cls_hi_red = cls_hi_red - CLS_W'(64'(CLASS_COUNT) << k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: finish class index, issue table read
    // ------------------------------------------------------------------
    logic [CLS_W-1:0]          a_cls_reg;
    logic [VERTEX_ID_BITS-1:0] a_vid_reg;
    logic                      a_ori_reg;
    logic [POSITION_BITS-1:0]  a_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_cls_reg <= cls_hi_red;
            a_vid_reg <= VERTEX_ID_BITS'(in_vid);
            a_ori_reg <= in_ori;
            a_pos_reg <= pos_cnt_reg;
        end
    end

    logic [CLS_W-1:0] cls_lo_red;
    logic [IDX_W-1:0] a_idx;

    always_comb begin
        cls_lo_red = a_cls_reg;
        for (int k = CLS_W / 2 - 1; k >= 0; k--) begin
            if (64'(cls_lo_red) >= (64'(CLASS_COUNT) << k)) begin
                cls_lo_red = cls_lo_red - CLS_W'(64'(CLASS_COUNT) << k);
            end
        end
    end

    assign a_idx = IDX_W'(cls_lo_red);

    // ------------------------------------------------------------------
    // Class table
    // ------------------------------------------------------------------
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rdata;

    logic [IDX_W-1:0]          b_idx_reg;
    logic [VERTEX_ID_BITS-1:0] b_vid_reg;
    logic                      b_ori_reg;
    logic [POSITION_BITS-1:0]  b_pos_reg;
    logic [ENT_W-1:0]          b_wr_ent;

    assign b_wr_ent = {1'b1, b_pos_reg, b_vid_reg, b_ori_reg};

    // Clearing pass owns the write port; no beat is in flight meanwhile.
    always_comb begin
        if (clr_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = b_valid_reg;
            ram_waddr = b_idx_reg;
            ram_wdata = b_wr_ent;
        end
    end

    crpf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CLASS_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (a_idx),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage B: compare, normalise, write back
    // ------------------------------------------------------------------
    // Forwarding: stage B writing the entry stage A reads in the same cycle.
    logic             fwd_hit_reg;
    logic [ENT_W-1:0] fwd_ent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            b_valid_reg <= a_valid_reg;
            fwd_hit_reg <= a_valid_reg && b_valid_reg && (a_idx == b_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_ent_reg <= b_wr_ent;
        if (a_valid_reg) begin
            b_idx_reg <= a_idx;
            b_vid_reg <= a_vid_reg;
            b_ori_reg <= a_ori_reg;
            b_pos_reg <= a_pos_reg;
        end
    end

    logic [ENT_W-1:0]          prev_ent;
    logic                      prev_seen;
    logic [POSITION_BITS-1:0]  prev_pos;
    logic [VERTEX_ID_BITS-1:0] prev_vid;
    logic                      prev_ori;
    logic [POSITION_BITS-1:0]  pos_gap;
    logic                      gap_ok;
    logic                      both_rev;
    logic                      pair_push;
    pair_t                     pair;

    assign prev_ent  = fwd_hit_reg ? fwd_ent_reg : ram_rdata;
    assign prev_seen = prev_ent[SEEN_B];
    assign prev_pos  = prev_ent[SEEN_B-1:POS_LO];
    assign prev_vid  = prev_ent[POS_LO-1:VID_LO];
    assign prev_ori  = prev_ent[0];

    // At least two positions apart; equal positions occur after saturation
    assign pos_gap   = b_pos_reg - prev_pos;
    assign gap_ok    = (b_pos_reg > prev_pos) && (pos_gap != POSITION_BITS'(1));
    assign pair_push = b_valid_reg && prev_seen && gap_ok;
    assign both_rev  = prev_ori && b_ori_reg;

    always_comb begin
        if (both_rev) begin
            pair.start_vertex      = OUT_VID_W'(b_vid_reg);
            pair.start_orientation = 1'b0;
            pair.end_vertex        = OUT_VID_W'(prev_vid);
            pair.end_orientation   = 1'b0;
        end else begin
            pair.start_vertex      = OUT_VID_W'(prev_vid);
            pair.start_orientation = prev_ori;
            pair.end_vertex        = OUT_VID_W'(b_vid_reg);
            pair.end_orientation   = b_ori_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result queue and master port
    // ------------------------------------------------------------------
    pair_t head;

    crpf_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (pair_push),
        .push_data (pair),
        .pop       (m_tready),
        .head      (head),
        .status    (fifo_st)
    );

    assign m_tvalid = !fifo_st.empty;
    assign m_tdata  = {(M_TDATA_W - 2*OUT_VID_W - 2)'(0), head};

endmodule

// ----- src/crpf_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module crpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/crpf_out_fifo.sv -----
`timescale 1ns / 1ps
// Small result queue between the pair stage and the master port.
// Depends on crpf_pkg.
module crpf_out_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  crpf_pkg::pair_t       push_data,
    input  logic                  pop,
    output crpf_pkg::pair_t       head,
    output crpf_pkg::fifo_status_t status
);
    import crpf_pkg::*;

    pair_t                 slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_W-1:0] level_reg, level_next;
    logic                  do_pop;

    assign do_pop = pop && (level_reg != '0);

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (!push && do_pop) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.level = level_reg;
    assign status.empty = (level_reg == '0);

endmodule

// ----- src/crpf_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the class repeat pair finder, bound to the top level.
// Depends on crpf_pkg and class_repeat_pair_finder.
module crpf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [crpf_pkg::M_TDATA_W-1:0] m_tdata
);
    import crpf_pkg::*;

    // Reset empties the queue and starts the clearing pass
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s_tready))
        else $error("outputs not idle after reset");

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

    // Normalised pair is never reverse at both ends
    a_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[OUT_VID_W] && m_tdata[2*OUT_VID_W+1]))
        else $error("pair left reverse at both ends");

    // A fresh result follows an accepted input beat by the pipeline delay
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
        else $error("result beat without matching input beat");

endmodule

bind class_repeat_pair_finder crpf_checker u_crpf_checker (.*);

// ----- bench/tb_class_repeat_pair_finder.sv -----
`timescale 1ns / 1ps
// Self-checking bench for class_repeat_pair_finder: drives classed vertex beats, predicts
// each emitted pair from its own class table and compares field by field.
// Depends on crpf_pkg and the class_repeat_pair_finder RTL.
module tb_class_repeat_pair_finder;
    import crpf_pkg::*;

    // Clock period and run ceiling. The ceiling covers the table clear
    // after reset plus ~1400 beats with random gaps and stalls, many times over.
    localparam int  CLK_HALF    = 4;
    localparam int  IDLE_PCT    = 34;
    localparam time RUN_LIMIT   = 4ms;
    localparam int  DRAIN_CYC   = 12;   // pipeline is two deep plus a 4-entry queue
    localparam int  PRINT_CAP   = 40;
    localparam int  N_CLASSES   = 4096;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Set during the burst test: both sides run flat out, no gaps, no stalls
    logic steady = 1'b0;
    int   err_count = 0;

    // Predictor state: one entry per class, plus the shared position counter
    logic [31:0] pos_count;
    logic        seen_bit  [N_CLASSES];
    logic [31:0] seen_pos  [N_CLASSES];
    logic [31:0] seen_vid  [N_CLASSES];
    logic        seen_ori  [N_CLASSES];

    // Pairs predicted but not yet seen on the master port, oldest first
    pair_t pending_pairs[$];

    class_repeat_pair_finder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Sink back-pressure: stalls about a third of cycles, none while steady
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Appends one predicted pair at the young end of the queue
    task automatic enqueue_pair(input pair_t p);
        pending_pairs = {pending_pairs, p};
    endtask

    // Table update for one accepted beat; queues a pair when the class recurs
    // at least two positions after its last sighting. Reverse/reverse pairs are
    // flipped end for start and both marked forward.
    task automatic track_class_item(input logic ori, input logic [31:0] vid,
                                    input logic [11:0] cls);
        pair_t p;
        p = '0;
        if (seen_bit[cls] && pos_count > seen_pos[cls]
                && (pos_count - seen_pos[cls]) > 32'd1) begin
            if (seen_ori[cls] && ori) begin
                p.start_vertex      = vid;
                p.start_orientation = 1'b0;
                p.end_vertex        = seen_vid[cls];
                p.end_orientation   = 1'b0;
            end else begin
                p.start_vertex      = seen_vid[cls];
                p.start_orientation = seen_ori[cls];
                p.end_vertex        = vid;
                p.end_orientation   = ori;
            end
            enqueue_pair(p);
        end
        seen_bit[cls] = 1'b1;
        seen_pos[cls] = pos_count;
        seen_vid[cls] = vid;
        seen_ori[cls] = ori;
        // Saturates at all ones; 2^32 beats are out of reach in simulation
        if (pos_count != 32'hFFFF_FFFF)
            pos_count = pos_count + 32'd1;
    endtask

    // Drive one beat on the slave port and hold it until taken. Valid stays
    // high across back-to-back beats; a gap lowers it for whole cycles only.
    task automatic send_beat(input logic ori, input logic [31:0] vid,
                             input logic [11:0] cls);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cls, vid, ori};
        do @(posedge aclk); while (!s_tready);
        track_class_item(ori, vid, cls);
    endtask

    // Result checker: every accepted master beat against the oldest prediction
    always @(posedge aclk) begin
        pair_t got;
        pair_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = pair_t'(m_tdata[$bits(pair_t)-1:0]);
            if (pending_pairs.size() == 0) begin
                report_mismatch($sformatf("unexpected pair %h", got));
            end else begin
                want = pending_pairs.pop_front();
                if (got.start_vertex !== want.start_vertex)
                    report_mismatch($sformatf("start_vertex %h want %h",
                        got.start_vertex, want.start_vertex));
                if (got.start_orientation !== want.start_orientation)
                    report_mismatch($sformatf("start_orientation %b want %b",
                        got.start_orientation, want.start_orientation));
                if (got.end_vertex !== want.end_vertex)
                    report_mismatch($sformatf("end_vertex %h want %h",
                        got.end_vertex, want.end_vertex));
                if (got.end_orientation !== want.end_orientation)
                    report_mismatch($sformatf("end_orientation %b want %b",
                        got.end_orientation, want.end_orientation));
            end
        end
    end

    // New classes only, at the index extremes and alternating bit patterns:
    // nothing may come out
    task automatic test_first_sightings();
        send_beat(1'b0, 32'h0000_0000, 12'h000);
        send_beat(1'b1, 32'hFFFF_FFFF, 12'hFFF);
        send_beat(1'b0, 32'h5555_5555, 12'h555);
        send_beat(1'b1, 32'hAAAA_AAAA, 12'hAAA);
    endtask

    // Same class on consecutive positions: adjacent repeats never pair,
    // and the table must follow the latest beat each time
    task automatic test_adjacent_repeat();
        send_beat(1'b0, 32'h0000_0011, 12'h007);
        send_beat(1'b1, 32'h0000_0022, 12'h007);
        send_beat(1'b0, 32'h0000_0033, 12'h007);
    endtask

    // One filler beat between repeats, walking through all four orientation
    // combinations: fwd/fwd, fwd/rev, rev/rev (flipped), rev/fwd.
    // The filler class itself recurs every other beat and pairs too.
    task automatic test_orientation_pairs();
        send_beat(1'b0, 32'h0000_0000, 12'h009);
        send_beat(1'b0, 32'h1234_5678, 12'h00A);
        send_beat(1'b0, 32'hFFFF_FFFF, 12'h009);
        send_beat(1'b1, 32'h8765_4321, 12'h00A);
        send_beat(1'b1, 32'h0000_0000, 12'h009);
        send_beat(1'b1, 32'hDEAD_BEEF, 12'h00A);
        send_beat(1'b1, 32'hFFFF_FFFF, 12'h009);
        send_beat(1'b0, 32'h0000_0001, 12'h00A);
        send_beat(1'b0, 32'h8000_0000, 12'h009);
    endtask

    // Long distance repeats: classes first seen at the top of the run
    task automatic test_old_classes();
        send_beat(1'b1, 32'h0F0F_0F0F, 12'h000);
        send_beat(1'b1, 32'hF0F0_F0F0, 12'hFFF);
    endtask

    // Random traffic. Most beats come from a small pool of classes so that
    // repeats and pairs are frequent; some are adjacent repeats and some
    // land anywhere in the table.
    task automatic test_random_traffic(input int n_beats);
        logic [11:0] pool [16];
        logic [11:0] cls;
        logic [11:0] prev_cls;
        logic [31:0] vid;
        int          pick;
        for (int i = 0; i < 16; i++)
            pool[i] = 12'($urandom_range(0, N_CLASSES - 1));
        prev_cls = pool[0];
        for (int i = 0; i < n_beats; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                cls = pool[$urandom_range(0, 15)];
            else if (pick < 80)
                cls = prev_cls;
            else
                cls = 12'($urandom_range(0, N_CLASSES - 1));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                vid = 32'h0000_0000;
            else if (pick == 1)
                vid = 32'hFFFF_FFFF;
            else
                vid = $urandom;
            send_beat(1'($urandom_range(0, 1)), vid, cls);
            prev_cls = cls;
        end
    endtask

    // Same mix at full rate on both sides: one beat per cycle, no stalls
    task automatic test_burst_no_gaps(input int n_beats);
        steady = 1'b1;
        test_random_traffic(n_beats);
        steady = 1'b0;
    endtask

    initial begin
        pos_count = '0;
        for (int i = 0; i < N_CLASSES; i++)
            seen_bit[i] = 1'b0;

        // Reset is held low at the start; the block then clears its table with
        // s_tready low, which the first send simply waits out.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_first_sightings();
        test_adjacent_repeat();
        test_orientation_pairs();
        test_old_classes();
        test_random_traffic(800);
        test_burst_no_gaps(300);
        test_random_traffic(300);

        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_pairs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (err_count == 0)
            $display("class_repeat_pair_finder regression: pass");
        else
            $display("class_repeat_pair_finder regression: fail");
        $finish;
    end

    // Hang guard
    initial begin
        #RUN_LIMIT;
        $display("class_repeat_pair_finder regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
src/crpf_pkg.sv
src/crpf_ram.sv
src/crpf_out_fifo.sv
src/class_repeat_pair_finder.sv
src/crpf_checker.sv
bench/tb_class_repeat_pair_finder.sv
